[rtl/stt_pkg.sv]
// package for the source text tokenizer: token kinds, lexer modes and byte classes
// no dependencies
`default_nettype none

package stt_pkg;

    localparam int INT_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int KIND_WIDTH  = 4;
    localparam int MAX_RESULTS = 6;
    localparam int KW_LEN      = 5;
    localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);
    localparam int KW_WIDTH    = $clog2(KW_LEN + 1);

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_EOF     = 4'd0,
        KIND_INT     = 4'd1,
        KIND_ID_CHAR = 4'd2,
        KIND_ID_END  = 4'd3,
        KIND_KW      = 4'd4,
        KIND_STR     = 4'd5,
        KIND_STR_END = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_UNKNOWN = 4'd9
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_INT  = 5'b00010,
        MODE_ID   = 5'b00100,
        MODE_STR  = 5'b01000,
        MODE_ESC  = 5'b10000
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5f;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_id_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // letters of the keyword print
    function automatic logic [7:0] kw_char(input logic [KW_WIDTH-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h69;
            3'd3:    ch = 8'h6e;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6e:   r = 8'd10;
            8'h72:   r = 8'd13;
            8'h74:   r = 8'd9;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/source_text_tokenizer_top.sv]
// source text tokenizer: one byte or end marker in, a burst of token results out
// results of an item appear in the cycle after it is accepted (registered)
// throughput: one item per cycle while out_ready is high and items give at most
//   one result each; an item giving more holds the input while the buffer drains
// reset: rst_n asynchronous, active low; lexer idle, buffer empty
// depends on stt_pkg
`default_nettype none

module source_text_tokenizer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     char_in,
    input  wire logic                           end_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [stt_pkg::KIND_WIDTH-1:0]      kind,
    output logic [stt_pkg::VALUE_WIDTH-1:0]     value,
    output logic                                last
);
    import stt_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [INT_WIDTH-1:0]   accum_reg, accum_next;
    logic [KW_WIDTH-1:0]    kw_reg, kw_next;
    logic                   div_reg, div_next;

    kind_t                  buf_kind_reg  [MAX_RESULTS];
    logic [VALUE_WIDTH-1:0] buf_value_reg [MAX_RESULTS];
    logic [CNT_WIDTH-1:0]   buf_cnt_reg, buf_cnt_next;
    logic [CNT_WIDTH-1:0]   buf_rd_reg, buf_rd_next;

    kind_t                  res_kind  [MAX_RESULTS];
    logic [VALUE_WIDTH-1:0] res_value [MAX_RESULTS];
    logic [CNT_WIDTH-1:0]   res_cnt;

    logic in_take, out_take, rd_last, do_idle;

    assign out_valid = (buf_rd_reg != buf_cnt_reg);
    assign rd_last   = (buf_rd_reg == buf_cnt_reg - CNT_WIDTH'(1));
    assign out_take  = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_take && rd_last);
    assign in_take   = in_valid && in_ready;

    assign kind  = buf_kind_reg[buf_rd_reg[CNT_WIDTH-1:0]];
    assign value = buf_value_reg[buf_rd_reg[CNT_WIDTH-1:0]];
    assign last  = rd_last;

    // token results of one item, in order
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        kw_next    = kw_reg;
        div_next   = div_reg;
        res_cnt    = '0;
        do_idle    = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_kind[i]  = KIND_EOF;
            res_value[i] = '0;
        end

        if (end_in)
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    res_kind[res_cnt]  = KIND_INT;
                    res_value[res_cnt] = VALUE_WIDTH'(accum_reg);
                    res_cnt            = res_cnt + CNT_WIDTH'(1);
                    accum_next         = '0;
                end
                MODE_ID:
                begin
                    if (!div_reg && kw_reg == KW_WIDTH'(KW_LEN))
                    begin
                        res_kind[res_cnt] = KIND_KW;
                        res_cnt           = res_cnt + CNT_WIDTH'(1);
                    end
                    else
                    begin
                        if (!div_reg)
                        begin
                            for (int i = 0; i < KW_LEN; i++)
                            begin
                                if (KW_WIDTH'(i) < kw_reg)
                                begin
                                    res_kind[res_cnt]  = KIND_ID_CHAR;
                                    res_value[res_cnt] = VALUE_WIDTH'(kw_char(KW_WIDTH'(i)));
                                    res_cnt            = res_cnt + CNT_WIDTH'(1);
                                end
                            end
                        end
                        res_kind[res_cnt] = KIND_ID_END;
                        res_cnt           = res_cnt + CNT_WIDTH'(1);
                    end
                    kw_next  = '0;
                    div_next = 1'b0;
                end
                MODE_STR, MODE_ESC:
                begin
                    res_kind[res_cnt] = KIND_STR_END;
                    res_cnt           = res_cnt + CNT_WIDTH'(1);
                end
                default:
                begin
                end
            endcase
            mode_next         = MODE_IDLE;
            res_kind[res_cnt] = KIND_EOF;
            res_cnt           = res_cnt + CNT_WIDTH'(1);
        end
        else
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit(char_in))
                    begin
                        accum_next = (accum_reg << 3) + (accum_reg << 1)
                                   + INT_WIDTH'(char_in - 8'h30);
                    end
                    else
                    begin
                        res_kind[res_cnt]  = KIND_INT;
                        res_value[res_cnt] = VALUE_WIDTH'(accum_reg);
                        res_cnt            = res_cnt + CNT_WIDTH'(1);
                        accum_next         = '0;
                        do_idle            = 1'b1;
                    end
                end
                MODE_ID:
                begin
                    if (is_id_char(char_in))
                    begin
                        if (div_reg)
                        begin
                            res_kind[res_cnt]  = KIND_ID_CHAR;
                            res_value[res_cnt] = VALUE_WIDTH'(char_in);
                            res_cnt            = res_cnt + CNT_WIDTH'(1);
                        end
                        else if (kw_reg < KW_WIDTH'(KW_LEN) && char_in == kw_char(kw_reg))
                        begin
                            kw_next = kw_reg + KW_WIDTH'(1);
                        end
                        else
                        begin
                            for (int i = 0; i < KW_LEN; i++)
                            begin
                                if (KW_WIDTH'(i) < kw_reg)
                                begin
                                    res_kind[res_cnt]  = KIND_ID_CHAR;
                                    res_value[res_cnt] = VALUE_WIDTH'(kw_char(KW_WIDTH'(i)));
                                    res_cnt            = res_cnt + CNT_WIDTH'(1);
                                end
                            end
                            res_kind[res_cnt]  = KIND_ID_CHAR;
                            res_value[res_cnt] = VALUE_WIDTH'(char_in);
                            res_cnt            = res_cnt + CNT_WIDTH'(1);
                            div_next           = 1'b1;
                            kw_next            = '0;
                        end
                    end
                    else
                    begin
                        if (!div_reg && kw_reg == KW_WIDTH'(KW_LEN))
                        begin
                            res_kind[res_cnt] = KIND_KW;
                            res_cnt           = res_cnt + CNT_WIDTH'(1);
                        end
                        else
                        begin
                            if (!div_reg)
                            begin
                                for (int i = 0; i < KW_LEN; i++)
                                begin
                                    if (KW_WIDTH'(i) < kw_reg)
                                    begin
                                        res_kind[res_cnt]  = KIND_ID_CHAR;
                                        res_value[res_cnt] =
                                            VALUE_WIDTH'(kw_char(KW_WIDTH'(i)));
                                        res_cnt            = res_cnt + CNT_WIDTH'(1);
                                    end
                                end
                            end
                            res_kind[res_cnt] = KIND_ID_END;
                            res_cnt           = res_cnt + CNT_WIDTH'(1);
                        end
                        kw_next  = '0;
                        div_next = 1'b0;
                        do_idle  = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (char_in == CH_QUOTE)
                    begin
                        res_kind[res_cnt] = KIND_STR_END;
                        res_cnt           = res_cnt + CNT_WIDTH'(1);
                        mode_next         = MODE_IDLE;
                    end
                    else if (char_in == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res_kind[res_cnt]  = KIND_STR;
                        res_value[res_cnt] = VALUE_WIDTH'(char_in);
                        res_cnt            = res_cnt + CNT_WIDTH'(1);
                    end
                end
                MODE_ESC:
                begin
                    res_kind[res_cnt]  = KIND_STR;
                    res_value[res_cnt] = VALUE_WIDTH'(unescape(char_in));
                    res_cnt            = res_cnt + CNT_WIDTH'(1);
                    mode_next          = MODE_STR;
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // byte seen from idle, or the byte that ended a number or identifier
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                if (is_space(char_in))
                begin
                end
                else if (is_digit(char_in))
                begin
                    mode_next  = MODE_INT;
                    accum_next = INT_WIDTH'(char_in - 8'h30);
                end
                else if (is_id_start(char_in))
                begin
                    mode_next = MODE_ID;
                    if (char_in == kw_char('0))
                    begin
                        kw_next  = KW_WIDTH'(1);
                        div_next = 1'b0;
                    end
                    else
                    begin
                        res_kind[res_cnt]  = KIND_ID_CHAR;
                        res_value[res_cnt] = VALUE_WIDTH'(char_in);
                        res_cnt            = res_cnt + CNT_WIDTH'(1);
                        kw_next            = '0;
                        div_next           = 1'b1;
                    end
                end
                else if (char_in == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                end
                else if (char_in == CH_LPAREN)
                begin
                    res_kind[res_cnt] = KIND_LPAREN;
                    res_cnt           = res_cnt + CNT_WIDTH'(1);
                end
                else if (char_in == CH_RPAREN)
                begin
                    res_kind[res_cnt] = KIND_RPAREN;
                    res_cnt           = res_cnt + CNT_WIDTH'(1);
                end
                else
                begin
                    res_kind[res_cnt] = KIND_UNKNOWN;
                    res_cnt           = res_cnt + CNT_WIDTH'(1);
                end
            end
        end
    end

    always_comb
    begin
        buf_cnt_next = buf_cnt_reg;
        buf_rd_next  = buf_rd_reg;
        if (in_take)
        begin
            buf_cnt_next = res_cnt;
            buf_rd_next  = '0;
        end
        else if (out_take)
        begin
            if (rd_last)
            begin
                buf_cnt_next = '0;
                buf_rd_next  = '0;
            end
            else
            begin
                buf_rd_next = buf_rd_reg + CNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            accum_reg   <= '0;
            kw_reg      <= '0;
            div_reg     <= 1'b0;
            buf_cnt_reg <= '0;
            buf_rd_reg  <= '0;
        end
        else
        begin
            buf_cnt_reg <= buf_cnt_next;
            buf_rd_reg  <= buf_rd_next;
            if (in_take)
            begin
                mode_reg  <= mode_next;
                accum_reg <= accum_next;
                kw_reg    <= kw_next;
                div_reg   <= div_next;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_kind_reg[i]  <= res_kind[i];
                buf_value_reg[i] <= res_value[i];
            end
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= CNT_WIDTH'(MAX_RESULTS) && buf_rd_reg <= buf_cnt_reg)
        else $error("result buffer pointers out of range");

    a_eof_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_in) |=> out_valid)
        else $error("end marker gave no result");

    a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
        kw_reg <= KW_WIDTH'(KW_LEN))
        else $error("keyword match count out of range");

    a_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_reg && kw_reg != '0))
        else $error("diverged identifier still holds keyword chars");

    a_id_state: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_ID) |-> (!div_reg && kw_reg == '0))
        else $error("identifier state left over outside identifier");

endmodule

`default_nettype wire
